// ----- rtl/mac_entry_table_macros.svh -----
// ============================================================================
// MAC entry table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef MAC_ENTRY_TABLE_MACROS_SVH
`define MAC_ENTRY_TABLE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define MTE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define MTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that holds in the cycle after its trigger.
`define MTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mte_pkg.sv -----
// ============================================================================
// MAC entry table package
// Field widths, command codes, status codes and parameter defaults.
// ============================================================================
package mte_pkg;

    localparam int CMD_W  = 3;
    localparam int MAC_W  = 48;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

    localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR_DYN = 3'd5;

    localparam logic [STAT_W-1:0] STS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STS_BAD_INDEX = 2'd3;

endpackage

// ----- rtl/mte_ifs.sv -----
// ============================================================================
// MAC entry table channel interfaces
// Command and result channels with a valid and ready handshake.
// ============================================================================
interface mte_req_if;

    logic                         valid;
    logic                         ready;
    logic [mte_pkg::CMD_W-1:0]    cmd;
    logic [mte_pkg::MAC_W-1:0]    mac;
    logic                         entry_static;
    logic [mte_pkg::DATA_W-1:0]   entry_data;
    logic [mte_pkg::IDX_W-1:0]    index;

    modport source (output valid, cmd, mac, entry_static, entry_data, index, input ready);
    modport sink (input valid, cmd, mac, entry_static, entry_data, index, output ready);

endinterface

interface mte_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [mte_pkg::STAT_W-1:0]   status;
    logic [mte_pkg::MAC_W-1:0]    out_mac;
    logic                         out_static;
    logic [mte_pkg::DATA_W-1:0]   out_data;
    logic [mte_pkg::CNT_W-1:0]    entry_count;
    logic [mte_pkg::CNT_W-1:0]    static_count;

    modport source (output valid, status, out_mac, out_static, out_data, entry_count,
                    static_count, input ready);
    modport sink (input valid, status, out_mac, out_static, out_data, entry_count,
                  static_count, output ready);

endinterface

// ----- rtl/mac_entry_table.sv -----
// ============================================================================
// MAC entry table
// Ordered table of MAC entries held in one synchronous memory, walked one
// entry per cycle for search, removal shift and dynamic-entry compaction.
// ============================================================================
//
//   Channel   Direction   Handshake        Payload
//   req       in          valid / ready    cmd, mac, entry_static, entry_data, index
//   rsp       out         valid / ready    status, out_mac, out_static, out_data, counts
//   cfg       in          cfg_we           cfg_wdata (max_entries)
//
// The single memory read port visits one entry per cycle, so how long an item holds the
// sequencer depends on its command: clear and unknown commands go straight to the final
// step, a read at index reads one entry, and search, removal and compaction walk the table.
// Reset clears the counts and the state; the memory needs no clearing pass.
// A new item is taken while the previous result waits in the output register.
// A stalled result holds the sequencer in its final step until it is taken.
//
module mac_entry_table #(
    parameter int TABLE_DEPTH = mte_pkg::TABLE_DEPTH_DEF,
    parameter int DATA_WIDTH  = mte_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mte_pkg::CNT_W-1:0] cfg_wdata,
    mte_req_if.sink                   req,
    mte_rsp_if.source                 rsp
);

    import mte_pkg::*;

    `include "mac_entry_table_macros.svh"

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int EW   = MAC_W + 1 + DATA_WIDTH;
    localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;
    localparam int IW   = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SHIFT   = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_RDAT    = 3'd4;
    localparam logic [2:0] S_RDWAIT  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [EW-1:0] entry_mem [TABLE_DEPTH];
    logic [EW-1:0] rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [CW-1:0]    pidx_reg, pidx_next;
    logic [CW-1:0]    kept_reg, kept_next;
    logic [CW-1:0]    tot_reg, tot_next;
    logic [CW-1:0]    st_cnt_reg, st_cnt_next;
    logic [CW-1:0]    dy_cnt_reg, dy_cnt_next;
    logic [CNT_W-1:0] max_reg, max_next;
    logic             out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [MAC_W-1:0]      mac_reg, mac_next;
    logic                  typ_reg, typ_next;
    logic [DATA_WIDTH-1:0] dat_reg, dat_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [MAC_W-1:0]  res_mac_reg, res_mac_next;
    logic              res_typ_reg, res_typ_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;

    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [MAC_W-1:0]  out_mac_reg, out_mac_next;
    logic              out_typ_reg, out_typ_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [CNT_W-1:0]  out_tot_reg, out_tot_next;
    logic [CNT_W-1:0]  out_st_reg, out_st_next;

    logic [MAC_W-1:0]      rd_mac;
    logic                  rd_typ;
    logic [DATA_WIDTH-1:0] rd_dat;
    logic [CW-1:0]         total;
    logic                  hit;
    logic                  table_full;
    logic                  index_bad;
    logic [CW-1:0]         shift_wa;
    logic [CW-1:0]         kept_inc;

    assign rd_mac = rd_reg[EW-1 -: MAC_W];
    assign rd_typ = rd_reg[DATA_WIDTH];
    assign rd_dat = rd_reg[DATA_WIDTH-1:0];

    assign total      = CW'(st_cnt_reg + dy_cnt_reg);
    assign hit        = pend_reg && (rd_mac == mac_reg);
    assign table_full = (CMPW'(tot_reg) >= CMPW'(max_reg))
                     || (CMPW'(tot_reg) >= CMPW'(TABLE_DEPTH));
    assign index_bad  = IW'(idx_reg) >= IW'(tot_reg);
    assign shift_wa   = pidx_reg - CW'(1);
    assign kept_inc   = (pend_reg && rd_typ) ? kept_reg + CW'(1) : kept_reg;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_mac      = out_mac_reg;
    assign rsp.out_static   = out_typ_reg;
    assign rsp.out_data     = out_data_reg;
    assign rsp.entry_count  = out_tot_reg;
    assign rsp.static_count = out_st_reg;

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        kept_next       = kept_reg;
        tot_next        = tot_reg;
        st_cnt_next     = st_cnt_reg;
        dy_cnt_next     = dy_cnt_reg;
        max_next        = cfg_we ? cfg_wdata : max_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        mac_next        = mac_reg;
        typ_next        = typ_reg;
        dat_next        = dat_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_mac_next    = res_mac_reg;
        res_typ_next    = res_typ_reg;
        res_data_next   = res_data_reg;
        out_status_next = out_status_reg;
        out_mac_next    = out_mac_reg;
        out_typ_next    = out_typ_reg;
        out_data_next   = out_data_reg;
        out_tot_next    = out_tot_reg;
        out_st_next     = out_st_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        mem_ra          = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next        = req.cmd;
                    mac_next        = req.mac;
                    typ_next        = req.entry_static;
                    dat_next        = DATA_WIDTH'(req.entry_data);
                    idx_next        = req.index;
                    tot_next        = total;
                    ptr_next        = '0;
                    pend_next       = 1'b0;
                    kept_next       = '0;
                    res_status_next = STS_OK;
                    res_mac_next    = '0;
                    res_typ_next    = 1'b0;
                    res_data_next   = '0;
                    if (req.cmd inside {CMD_UPDATE, CMD_REMOVE, CMD_LOOKUP})
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.cmd == CMD_READ_AT)
                    begin
                        state_next = S_RDAT;
                    end
                    else if (req.cmd == CMD_CLEAR_DYN)
                    begin
                        state_next = S_COMPACT;
                    end
                    else
                    begin
                        if (req.cmd == CMD_CLEAR)
                        begin
                            st_cnt_next = '0;
                            dy_cnt_next = '0;
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    case (cmd_reg)
                        CMD_UPDATE:
                        begin
                            mem_we = 1'b1;
                            mem_wa = pidx_reg[AW-1:0];
                            mem_wd = {rd_mac, typ_reg, dat_reg};
                            if (rd_typ && !typ_reg)
                            begin
                                st_cnt_next = st_cnt_reg - CW'(1);
                                dy_cnt_next = dy_cnt_reg + CW'(1);
                            end
                            else if (!rd_typ && typ_reg)
                            begin
                                st_cnt_next = st_cnt_reg + CW'(1);
                                dy_cnt_next = dy_cnt_reg - CW'(1);
                            end
                            state_next = S_DONE;
                        end
                        CMD_REMOVE:
                        begin
                            if (rd_typ)
                            begin
                                st_cnt_next = st_cnt_reg - CW'(1);
                            end
                            else
                            begin
                                dy_cnt_next = dy_cnt_reg - CW'(1);
                            end
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            res_mac_next  = rd_mac;
                            res_typ_next  = rd_typ;
                            res_data_next = DATA_W'(rd_dat);
                            state_next    = S_DONE;
                        end
                    endcase
                end
                else if (ptr_reg >= tot_reg)
                begin
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        if (table_full)
                        begin
                            res_status_next = STS_FULL;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = tot_reg[AW-1:0];
                            mem_wd = {mac_reg, typ_reg, dat_reg};
                            if (typ_reg)
                            begin
                                st_cnt_next = st_cnt_reg + CW'(1);
                            end
                            else
                            begin
                                dy_cnt_next = dy_cnt_reg + CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        res_status_next = STS_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg;
                    ptr_next  = ptr_reg + CW'(1);
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = shift_wa[AW-1:0];
                    mem_wd = rd_reg;
                end
                if (ptr_reg < tot_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_COMPACT:
            begin
                if (pend_reg && rd_typ)
                begin
                    mem_we = 1'b1;
                    mem_wa = kept_reg[AW-1:0];
                    mem_wd = rd_reg;
                end
                kept_next = kept_inc;
                if (ptr_reg < tot_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else
                begin
                    st_cnt_next = kept_inc;
                    dy_cnt_next = '0;
                    state_next  = S_DONE;
                end
            end

            S_RDAT:
            begin
                if (index_bad)
                begin
                    res_status_next = STS_BAD_INDEX;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_ra     = AW'(idx_reg);
                    state_next = S_RDWAIT;
                end
            end

            S_RDWAIT:
            begin
                res_mac_next  = rd_mac;
                res_typ_next  = rd_typ;
                res_data_next = DATA_W'(rd_dat);
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_mac_next    = res_mac_reg;
                    out_typ_next    = res_typ_reg;
                    out_data_next   = res_data_reg;
                    out_tot_next    = CNT_W'(total);
                    out_st_next     = CNT_W'(st_cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            kept_reg      <= '0;
            tot_reg       <= '0;
            st_cnt_reg    <= '0;
            dy_cnt_reg    <= '0;
            max_reg       <= MAX_ENTRIES_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            pidx_reg      <= pidx_next;
            kept_reg      <= kept_next;
            tot_reg       <= tot_next;
            st_cnt_reg    <= st_cnt_next;
            dy_cnt_reg    <= dy_cnt_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        mac_reg        <= mac_next;
        typ_reg        <= typ_next;
        dat_reg        <= dat_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_mac_reg    <= res_mac_next;
        res_typ_reg    <= res_typ_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_mac_reg    <= out_mac_next;
        out_typ_reg    <= out_typ_next;
        out_data_reg   <= out_data_next;
        out_tot_reg    <= out_tot_next;
        out_st_reg     <= out_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_reg <= entry_mem[mem_ra];
    end

    `MTE_ASSERT_ALWAYS(a_count_bound, (CW+1)'(st_cnt_reg) + (CW+1)'(dy_cnt_reg) <= (CW+1)'(TABLE_DEPTH), "entry count exceeds table depth")
    `MTE_ASSERT_IMPL(a_write_in_range, mem_we, CW'(mem_wa) <= tot_reg, "memory write beyond table end")
    `MTE_ASSERT_IMPL(a_compact_order, state_reg == S_COMPACT, kept_reg <= ptr_reg, "compaction write overtakes read")
    `MTE_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg != S_IDLE, "accepted item left sequencer idle")
    `MTE_ASSERT_NEXT(a_result_loaded, state_reg == S_DONE && (!out_valid_reg || rsp.ready), out_valid_reg && state_reg == S_IDLE, "finished item not moved to output")

endmodule

// ----- sim/mac_entry_table_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// MAC entry table testbench
// Drives table commands through the request channel and checks every result
// against its directed row or a predictor holding its own copy of the table,
// its counts and the capacity register. A short table of directed commands
// comes first, then random phases at several capacities and idling patterns.
// ============================================================================
module mac_entry_table_tb;

    import mte_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int POOL_SIZE = 80;
    localparam int N_ROWS    = 22;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [MAC_W-1:0]  mac;
        logic              entry_static;
        logic [DATA_W-1:0] entry_data;
        logic [IDX_W-1:0]  index;
    } table_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MAC_W-1:0]  mac;
        logic              is_static;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  statics;
    } table_result_t;

    typedef struct packed {
        table_cmd_t    c;
        logic          typed;
        table_result_t r;
    } directed_row_t;

    typedef enum {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;
    typedef enum {MIX_FILL, MIX_GENERAL} mix_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    mte_req_if req_ch ();
    mte_rsp_if rsp_ch ();

    mac_entry_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [MAC_W-1:0]  tbl_mac [DEPTH];
    logic              tbl_static [DEPTH];
    logic [DATA_W-1:0] tbl_data [DEPTH];
    int n_static;
    int n_dynamic;
    int capacity_reg;

    table_result_t expected_q [$];
    int outstanding;
    int failures;
    int send_idle_pct;
    int recv_stall_pct;
    logic [MAC_W-1:0] mac_pool [POOL_SIZE];
    directed_row_t directed_rows [N_ROWS];

    always #5 clk = ~clk;

    function automatic logic [MAC_W-1:0] random_mac();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[15:0], lo};
    endfunction

    function automatic int find_entry(logic [MAC_W-1:0] key, int total);
        for (int i = 0; i < total && i < DEPTH; i++)
        begin
            if (tbl_mac[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic void copy_entry(int dst, int src);
        tbl_mac[dst]    = tbl_mac[src];
        tbl_static[dst] = tbl_static[src];
        tbl_data[dst]   = tbl_data[src];
    endfunction

    function automatic table_result_t apply_command(table_cmd_t c);
        table_result_t r;
        int total;
        int cap;
        int pos;
        int kept;
        r = '0;
        total = n_static + n_dynamic;
        cap = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
        case (c.cmd)
            CMD_UPDATE:
            begin
                pos = find_entry(c.mac, total);
                if (pos >= 0)
                begin
                    if (tbl_static[pos] != c.entry_static)
                    begin
                        if (tbl_static[pos])
                        begin
                            n_static--;
                            n_dynamic++;
                        end
                        else
                        begin
                            n_dynamic--;
                            n_static++;
                        end
                    end
                    tbl_static[pos] = c.entry_static;
                    tbl_data[pos]   = c.entry_data;
                end
                else if (total >= cap)
                    r.status = STS_FULL;
                else
                begin
                    tbl_mac[total]    = c.mac;
                    tbl_static[total] = c.entry_static;
                    tbl_data[total]   = c.entry_data;
                    if (c.entry_static)
                        n_static++;
                    else
                        n_dynamic++;
                end
            end
            CMD_REMOVE:
            begin
                pos = find_entry(c.mac, total);
                if (pos < 0)
                    r.status = STS_NOT_FOUND;
                else
                begin
                    if (tbl_static[pos])
                        n_static--;
                    else
                        n_dynamic--;
                    for (int i = pos; i + 1 < total; i++)
                        copy_entry(i, i + 1);
                end
            end
            CMD_LOOKUP:
            begin
                pos = find_entry(c.mac, total);
                if (pos < 0)
                    r.status = STS_NOT_FOUND;
                else
                begin
                    r.mac       = tbl_mac[pos];
                    r.is_static = tbl_static[pos];
                    r.data      = tbl_data[pos];
                end
            end
            CMD_READ_AT:
            begin
                if (int'(c.index) >= total)
                    r.status = STS_BAD_INDEX;
                else
                begin
                    r.mac       = tbl_mac[c.index];
                    r.is_static = tbl_static[c.index];
                    r.data      = tbl_data[c.index];
                end
            end
            CMD_CLEAR:
            begin
                n_static  = 0;
                n_dynamic = 0;
            end
            CMD_CLEAR_DYN:
            begin
                kept = 0;
                for (int i = 0; i < total && i < DEPTH; i++)
                begin
                    if (tbl_static[i])
                    begin
                        if (kept != i)
                            copy_entry(kept, i);
                        kept++;
                    end
                end
                n_static  = kept;
                n_dynamic = 0;
            end
            default:
            begin
            end
        endcase
        r.total   = CNT_W'(n_static + n_dynamic);
        r.statics = CNT_W'(n_static);
        return r;
    endfunction

    function automatic table_cmd_t step(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
                                        logic st, logic [DATA_W-1:0] data,
                                        logic [IDX_W-1:0] idx);
        return '{cmd, mac, st, data, idx};
    endfunction

    function automatic table_result_t want(logic [STAT_W-1:0] status, logic [MAC_W-1:0] mac,
                                           logic st, logic [DATA_W-1:0] data,
                                           logic [CNT_W-1:0] total, logic [CNT_W-1:0] stc);
        return '{status, mac, st, data, total, stc};
    endfunction

    function automatic table_cmd_t make_random_command(mix_t mix, int span);
        table_cmd_t c;
        int r;
        int total;
        total = n_static + n_dynamic;
        r = $urandom_range(99);
        if (mix == MIX_FILL)
            c.cmd = (r < 85) ? CMD_UPDATE : (r < 92) ? CMD_LOOKUP :
                    (r < 97) ? CMD_READ_AT : CMD_REMOVE;
        else
            c.cmd = (r < 35) ? CMD_UPDATE : (r < 50) ? CMD_REMOVE :
                    (r < 68) ? CMD_LOOKUP : (r < 84) ? CMD_READ_AT :
                    (r < 87) ? CMD_CLEAR : (r < 92) ? CMD_CLEAR_DYN :
                    (r < 96) ? CMD_RSVD_A : CMD_RSVD_B;
        c.mac = ($urandom_range(3) != 0) ? mac_pool[$urandom_range(span - 1)] : random_mac();
        c.entry_static = 1'($urandom_range(1));
        c.entry_data = $urandom;
        if (total > 0 && $urandom_range(3) != 0)
            c.index = IDX_W'($urandom_range(total - 1));
        else
            c.index = IDX_W'($urandom_range(DEPTH - 1));
        return c;
    endfunction

    task automatic note_failure(string what, table_result_t exp_r, table_result_t got_r);
        failures++;
        if (failures <= 10)
            $display("%0t: %s: expected sts=%0d mac=%h st=%0b data=%h tot=%0d stc=%0d, got sts=%0d mac=%h st=%0b data=%h tot=%0d stc=%0d",
                     $realtime, what, exp_r.status, exp_r.mac, exp_r.is_static, exp_r.data,
                     exp_r.total, exp_r.statics, got_r.status, got_r.mac, got_r.is_static,
                     got_r.data, got_r.total, got_r.statics);
    endtask

    task automatic set_pace(pace_t pace);
        send_idle_pct  = (pace == PACE_SENDER_IDLE) ? 87 : (pace == PACE_BOTH) ? 34 : 0;
        recv_stall_pct = (pace == PACE_RECEIVER_STALL) ? 87 : (pace == PACE_BOTH) ? 34 : 0;
    endtask

    // Called and returns at a falling edge.
    task automatic issue_command(table_cmd_t c, logic typed, table_result_t typed_r);
        table_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.cmd          = c.cmd;
        req_ch.mac          = c.mac;
        req_ch.entry_static = c.entry_static;
        req_ch.entry_data   = c.entry_data;
        req_ch.index        = c.index;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_command(c);
        expected_q.push_back(typed ? typed_r : predicted);
        outstanding++;
        @(negedge clk);
    endtask

    task automatic write_capacity(int value);
        while (outstanding != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = CNT_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        capacity_reg = value;
    endtask

    task automatic run_phase(int capacity, pace_t pace, mix_t mix, int span, int count);
        write_capacity(capacity);
        set_pace(pace);
        for (int k = 0; k < count; k++)
            issue_command(make_random_command(mix, span), 1'b0, '0);
        req_ch.valid = 1'b0;
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = {rsp_ch.status, rsp_ch.out_mac, rsp_ch.out_static, rsp_ch.out_data,
                   rsp_ch.entry_count, rsp_ch.static_count};
            if (expected_q.size() == 0)
                note_failure("result with none expected", '0, got);
            else
            begin
                exp_r = expected_q.pop_front();
                outstanding--;
                if (got !== exp_r)
                    note_failure("result mismatch", exp_r, got);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = '0;
        req_ch.mac          = '0;
        req_ch.entry_static = 1'b0;
        req_ch.entry_data   = '0;
        req_ch.index        = '0;
        n_static     = 0;
        n_dynamic    = 0;
        capacity_reg = int'(MAX_ENTRIES_RST);
        outstanding  = 0;
        failures     = 0;
        set_pace(PACE_FULL);
        for (int k = 0; k < DEPTH; k++)
        begin
            tbl_mac[k]    = '0;
            tbl_static[k] = 1'b0;
            tbl_data[k]   = '0;
        end
        for (int k = 0; k < POOL_SIZE; k++)
            mac_pool[k] = random_mac();

        directed_rows = '{
            '{step(CMD_LOOKUP, 48'h0, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_NOT_FOUND, 48'h0, 1'b0, 32'h0, 7'd0, 7'd0)},
            '{step(CMD_READ_AT, 48'h0, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_BAD_INDEX, 48'h0, 1'b0, 32'h0, 7'd0, 7'd0)},
            '{step(CMD_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h0, 6'd0), 1'b1,
              want(STS_NOT_FOUND, 48'h0, 1'b0, 32'h0, 7'd0, 7'd0)},
            '{step(CMD_CLEAR_DYN, 48'h0, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd0, 7'd0)},
            '{step(CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 6'd63), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd1, 7'd1)},
            '{step(CMD_UPDATE, 48'h0, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd2, 7'd1)},
            '{step(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_OK, 48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 7'd2, 7'd1)},
            '{step(CMD_READ_AT, 48'h0, 1'b0, 32'h0, 6'd1), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd2, 7'd1)},
            '{step(CMD_UPDATE, 48'h0, 1'b1, 32'h1234_5678, 6'd0), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd2, 7'd2)},
            '{step(CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd2, 7'd1)},
            '{step(CMD_UPDATE, 48'h0123_4567_89AB, 1'b0, 32'hA5A5_A5A5, 6'd0), 1'b0, '0},
            '{step(CMD_UPDATE, 48'hFEDC_BA98_7654, 1'b1, 32'h5A5A_5A5A, 6'd0), 1'b0, '0},
            '{step(CMD_REMOVE, 48'h0, 1'b0, 32'h0, 6'd0), 1'b0, '0},
            '{step(CMD_READ_AT, 48'h0, 1'b0, 32'h0, 6'd2), 1'b0, '0},
            '{step(CMD_READ_AT, 48'h0, 1'b1, 32'h0, 6'd63), 1'b1,
              want(STS_BAD_INDEX, 48'h0, 1'b0, 32'h0, 7'd3, 7'd1)},
            '{step(CMD_RSVD_A, 48'h0123_4567_89AB, 1'b1, 32'hFFFF_FFFF, 6'd1), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd3, 7'd1)},
            '{step(CMD_RSVD_B, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd3, 7'd1)},
            '{step(CMD_LOOKUP, 48'h0123_4567_89AB, 1'b0, 32'h0, 6'd0), 1'b0, '0},
            '{step(CMD_CLEAR_DYN, 48'h0, 1'b0, 32'h0, 6'd0), 1'b0, '0},
            '{step(CMD_READ_AT, 48'h0, 1'b0, 32'h0, 6'd0), 1'b0, '0},
            '{step(CMD_CLEAR, 48'h0, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_OK, 48'h0, 1'b0, 32'h0, 7'd0, 7'd0)},
            '{step(CMD_READ_AT, 48'h0, 1'b0, 32'h0, 6'd0), 1'b1,
              want(STS_BAD_INDEX, 48'h0, 1'b0, 32'h0, 7'd0, 7'd0)}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < N_ROWS; k++)
            issue_command(directed_rows[k].c, directed_rows[k].typed, directed_rows[k].r);
        req_ch.valid = 1'b0;

        run_phase(64, PACE_FULL, MIX_FILL, POOL_SIZE, 140);
        run_phase(5, PACE_SENDER_IDLE, MIX_GENERAL, 12, 80);
        run_phase(0, PACE_RECEIVER_STALL, MIX_GENERAL, 12, 40);
        run_phase(63, PACE_BOTH, MIX_GENERAL, 40, 100);
        run_phase(64, PACE_FULL, MIX_GENERAL, POOL_SIZE, 60);

        while (outstanding != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (failures == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
